>>> design/ipr_pkg.sv
// ipr_pkg: shared constants, codes and controller/datapath types for the
// interval peak rebinner. No dependencies; compiled before every other file.
package ipr_pkg;

  // default widths handed to the top level parameters
  localparam int unsigned COORD_BITS_DEF = 30;
  localparam int unsigned SCORE_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned CFG_ADDR_BITS = 4;
  localparam int unsigned REG_IDX_BITS  = 2;

  // register indexes (byte address 4*index)
  localparam logic [REG_IDX_BITS-1:0] REG_RANGE_START = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_RANGE_END   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BIN_WIDTH   = 2'd2;

  // register reset values
  localparam int unsigned BIN_WIDTH_RST = 4;

  // input action codes
  localparam logic ACT_INTERVAL = 1'b0;
  localparam logic ACT_FLUSH    = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLASSIFY,
    ST_DIV_K,
    ST_AVAIL,
    ST_DIV_A,
    ST_EMIT
  } ipr_state_e;

  // what the pending result is and what follows its transfer
  typedef enum logic [1:0] {
    EK_FLUSH_BIN,
    EK_MARKER,
    EK_JUMP_OK,
    EK_JUMP_END
  } ipr_kind_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic restart;
    logic clear_peak;
    logic absorb;
    logic advance;
    logic div_start;
    logic div_sel_avail;
    logic load_jump;
    logic load_avail;
    logic zero_empt;
    logic emit;
    logic emit_marker;
    logic emit_done;
  } ipr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_flush;
    logic start_past;
    logic end_le_cur;
    logic ignore;
    logic in_bin;
    logic jump_ok;
    logic div_done;
    logic div_busy;
    logic out_free;
  } ipr_sts_t;

endpackage

>>> design/ipr_in_if.sv
// ipr_in_if: valid/ready channel carrying one scored interval or a flush.
// Depends on ipr_pkg for the tag width.
interface ipr_in_if #(
  parameter int unsigned COORD_BITS = ipr_pkg::COORD_BITS_DEF,
  parameter int unsigned SCORE_BITS = ipr_pkg::SCORE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [COORD_BITS-1:0]          seg_start;
  logic [COORD_BITS-1:0]          seg_end;
  logic signed [SCORE_BITS-1:0]   seg_score;
  logic [ipr_pkg::TAG_BITS-1:0]   seg_tag;

  modport source (output valid, action, seg_start, seg_end, seg_score, seg_tag,
                  input ready);
  modport sink (input valid, action, seg_start, seg_end, seg_score, seg_tag,
                output ready);
endinterface

>>> design/ipr_out_if.sv
// ipr_out_if: valid/ready channel carrying one closed bin or a run marker.
// Depends on ipr_pkg for the tag width.
interface ipr_out_if #(
  parameter int unsigned COORD_BITS = ipr_pkg::COORD_BITS_DEF,
  parameter int unsigned SCORE_BITS = ipr_pkg::SCORE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [COORD_BITS-1:0]          bin_first;
  logic [COORD_BITS-1:0]          bin_last;
  logic signed [SCORE_BITS-1:0]   peak_score;
  logic [ipr_pkg::TAG_BITS-1:0]   peak_tag;
  logic                           tag_valid;
  logic [COORD_BITS-1:0]          empty_after;
  logic                           run_done;

  modport source (output valid, bin_first, bin_last, peak_score, peak_tag, tag_valid,
                  empty_after, run_done, input ready);
  modport sink (input valid, bin_first, bin_last, peak_score, peak_tag, tag_valid,
                empty_after, run_done, output ready);
endinterface

>>> design/ipr_regs.sv
// ipr_regs: APB-style configuration registers (range start, range end, bin width).
// Depends on ipr_pkg for register indexes and reset values.
module ipr_regs #(
  parameter int unsigned COORD_BITS = ipr_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ipr_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ipr_pkg::APB_DW-1:0]         pwdata,
  output logic [ipr_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  output logic [COORD_BITS-1:0]              range_start_o,
  output logic [COORD_BITS-1:0]              range_end_o,
  output logic [COORD_BITS-1:0]              bin_width_o
);
  import ipr_pkg::*;

  logic [COORD_BITS-1:0]   range_start_q, range_end_q, bin_width_q;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_end_q   <= '0;
      bin_width_q   <= COORD_BITS'(BIN_WIDTH_RST);
    end else if (wr_en) begin
      case (reg_idx)
        REG_RANGE_START: range_start_q <= pwdata[COORD_BITS-1:0];
        REG_RANGE_END:   range_end_q   <= pwdata[COORD_BITS-1:0];
        REG_BIN_WIDTH:   bin_width_q   <= pwdata[COORD_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_RANGE_START: prdata = APB_DW'(range_start_q);
      REG_RANGE_END:   prdata = APB_DW'(range_end_q);
      REG_BIN_WIDTH:   prdata = APB_DW'(bin_width_q);
      default:         prdata = '0;
    endcase
  end

  assign range_start_o = range_start_q;
  assign range_end_o   = range_end_q;
  assign bin_width_o   = bin_width_q;

endmodule

>>> design/ipr_div.sv
// ipr_div: restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; used by ipr_dp for gap jumps and remaining-bin counts.
module ipr_div #(
  parameter int unsigned COORD_BITS = ipr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] num_i,
  input  logic [COORD_BITS-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] quo_o,
  output logic [COORD_BITS-1:0] rem_o
);
  localparam int unsigned CNT_BITS = $clog2(COORD_BITS + 1);

  logic                  busy_q, busy_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [COORD_BITS:0]   shifted, trial;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[COORD_BITS-1]};
    trial   = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(COORD_BITS);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CNT_BITS'(1);
        if (!trial[COORD_BITS]) begin
          rem_d = trial[COORD_BITS-1:0];
        end else begin
          rem_d = shifted[COORD_BITS-1:0];
        end
        quo_d = {quo_q[COORD_BITS-2:0], !trial[COORD_BITS]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> design/ipr_dp.sv
// ipr_dp: datapath of the rebinner: input capture, current bin and peak,
// divider operands, empty-bin count and the output register.
// Depends on ipr_pkg and ipr_div.
module ipr_dp #(
  parameter int unsigned COORD_BITS = ipr_pkg::COORD_BITS_DEF,
  parameter int unsigned SCORE_BITS = ipr_pkg::SCORE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ipr_pkg::ipr_cmd_t                cmd_i,
  output ipr_pkg::ipr_sts_t                sts_o,
  input  logic [COORD_BITS-1:0]            range_start_i,
  input  logic [COORD_BITS-1:0]            range_end_i,
  input  logic [COORD_BITS-1:0]            bin_width_i,
  input  logic                             action_i,
  input  logic [COORD_BITS-1:0]            seg_start_i,
  input  logic [COORD_BITS-1:0]            seg_end_i,
  input  logic signed [SCORE_BITS-1:0]     seg_score_i,
  input  logic [ipr_pkg::TAG_BITS-1:0]     seg_tag_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [COORD_BITS-1:0]            bin_first_o,
  output logic [COORD_BITS-1:0]            bin_last_o,
  output logic signed [SCORE_BITS-1:0]     peak_score_o,
  output logic [ipr_pkg::TAG_BITS-1:0]     peak_tag_o,
  output logic                             tag_valid_o,
  output logic [COORD_BITS-1:0]            empty_after_o,
  output logic                             run_done_o
);
  import ipr_pkg::*;

  // captured item
  logic                         act_q;
  logic [COORD_BITS-1:0]        s_q, e_q;
  logic signed [SCORE_BITS-1:0] score_q;
  logic [TAG_BITS-1:0]          tag_q;

  // bin state
  logic [COORD_BITS-1:0]        cur_q, nxt_q, empt_q;
  logic signed [SCORE_BITS-1:0] best_score_q;
  logic [TAG_BITS-1:0]          best_tag_q;
  logic                         tag_held_q;

  // output register
  logic                         out_valid_q;
  logic [COORD_BITS-1:0]        first_q, last_q, empty_q;
  logic signed [SCORE_BITS-1:0] pscore_q;
  logic [TAG_BITS-1:0]          ptag_q;
  logic                         tvalid_q, done_q;

  logic [COORD_BITS-1:0]        weff, last, div_num, quo, rem, jump_start;
  logic [COORD_BITS:0]          last_sum;
  logic [SCORE_BITS-1:0]        mag_new, mag_best;
  logic                         div_busy, div_done, out_free;

  // effective width and inclusive bin end, saturated
  assign weff     = (bin_width_i == '0) ? COORD_BITS'(1) : bin_width_i;
  assign last_sum = {1'b0, cur_q} + {1'b0, weff} - (COORD_BITS+1)'(1);
  assign last     = last_sum[COORD_BITS] ? '1 : last_sum[COORD_BITS-1:0];

  // magnitudes; the most negative score maps to its exact unsigned value
  assign mag_new  = score_q[SCORE_BITS-1] ? SCORE_BITS'(-score_q) : SCORE_BITS'(score_q);
  assign mag_best = best_score_q[SCORE_BITS-1] ? SCORE_BITS'(-best_score_q)
                                               : SCORE_BITS'(best_score_q);

  // divider operands: gap distance or bins left before range end
  assign div_num = cmd_i.div_sel_avail ? (range_end_i - COORD_BITS'(1) - cur_q)
                                       : (s_q - cur_q);

  ipr_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (weff),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  assign jump_start = s_q - rem;
  assign out_free   = !out_valid_q || out_ready_i;

  // status to the controller
  always_comb begin
    sts_o.is_flush   = (act_q == ACT_FLUSH);
    sts_o.start_past = (range_start_i >= range_end_i);
    sts_o.end_le_cur = (range_end_i <= cur_q);
    sts_o.ignore     = (e_q < cur_q);
    sts_o.in_bin     = (s_q <= last);
    sts_o.jump_ok    = (range_end_i > cur_q) && (jump_start < range_end_i);
    sts_o.div_done   = div_done;
    sts_o.div_busy   = div_busy;
    sts_o.out_free   = out_free;
  end

  // input capture; a reversed interval collapses to its start
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      s_q     <= seg_start_i;
      e_q     <= (seg_end_i < seg_start_i) ? seg_start_i : seg_end_i;
      score_q <= seg_score_i;
      tag_q   <= seg_tag_i;
    end
  end

  // current bin and held peak
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      best_score_q <= '0;
      best_tag_q   <= '0;
      tag_held_q   <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        cur_q <= range_start_i;
      end else if (cmd_i.advance) begin
        cur_q <= nxt_q;
      end
      if (cmd_i.restart || cmd_i.clear_peak) begin
        best_score_q <= '0;
        best_tag_q   <= '0;
        tag_held_q   <= 1'b0;
      end else if (cmd_i.advance) begin
        best_score_q <= score_q;
        best_tag_q   <= tag_q;
        tag_held_q   <= 1'b1;
      end else if (cmd_i.absorb) begin
        tag_held_q <= 1'b1;
        if (mag_new > mag_best) begin
          best_score_q <= score_q;
          best_tag_q   <= tag_q;
        end else if (!tag_held_q) begin
          best_tag_q <= tag_q;
        end
      end
    end
  end

  // jump target and empty-bin count
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_jump) begin
      empt_q <= quo - COORD_BITS'(1);
      nxt_q  <= jump_start;
    end else if (cmd_i.load_avail) begin
      empt_q <= quo;
    end else if (cmd_i.zero_empt) begin
      empt_q <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      done_q <= cmd_i.emit_done;
      if (cmd_i.emit_marker) begin
        first_q  <= '0;
        last_q   <= '0;
        pscore_q <= '0;
        ptag_q   <= '0;
        tvalid_q <= 1'b0;
        empty_q  <= '0;
      end else begin
        first_q  <= cur_q;
        last_q   <= last;
        pscore_q <= tag_held_q ? best_score_q : '0;
        ptag_q   <= tag_held_q ? best_tag_q : '0;
        tvalid_q <= tag_held_q;
        empty_q  <= empt_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_first_o   = first_q;
  assign bin_last_o    = last_q;
  assign peak_score_o  = pscore_q;
  assign peak_tag_o    = ptag_q;
  assign tag_valid_o   = tvalid_q;
  assign empty_after_o = empty_q;
  assign run_done_o    = done_q;

endmodule

>>> design/ipr_ctrl.sv
// ipr_ctrl: controller state machine of the rebinner; owns run state
// (bin open, past end) and sequences the datapath. Depends on ipr_pkg.
module ipr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ipr_pkg::ipr_sts_t sts_i,
  output ipr_pkg::ipr_cmd_t cmd_o
);
  import ipr_pkg::*;

  ipr_state_e state_q, state_d;
  ipr_kind_e  kind_q, kind_d;
  logic       bin_open_q, bin_open_d;
  logic       past_end_q, past_end_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= EK_MARKER;
      bin_open_q <= 1'b0;
      past_end_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      bin_open_q <= bin_open_d;
      past_end_q <= past_end_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    bin_open_d = bin_open_q;
    past_end_d = past_end_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_flush) begin
          if (bin_open_q) begin
            kind_d  = EK_FLUSH_BIN;
            state_d = ST_AVAIL;
          end else begin
            kind_d  = EK_MARKER;
            state_d = ST_EMIT;
          end
        end else if (past_end_q) begin
          state_d = ST_IDLE;
        end else if (!bin_open_q) begin
          // new run opens its first bin at range start
          cmd_o.restart = 1'b1;
          if (sts_i.start_past) begin
            past_end_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            bin_open_d = 1'b1;
            state_d    = ST_CLASSIFY;
          end
        end else begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (sts_i.ignore) begin
          state_d = ST_IDLE;
        end else if (sts_i.in_bin) begin
          cmd_o.absorb = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_K;
        end
      end
      ST_DIV_K: begin
        // gap distance in bins is ready
        if (sts_i.div_done) begin
          if (sts_i.jump_ok) begin
            cmd_o.load_jump = 1'b1;
            kind_d          = EK_JUMP_OK;
            state_d         = ST_EMIT;
          end else begin
            kind_d  = EK_JUMP_END;
            state_d = ST_AVAIL;
          end
        end
      end
      ST_AVAIL: begin
        if (sts_i.end_le_cur) begin
          cmd_o.zero_empt = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.div_start     = 1'b1;
          cmd_o.div_sel_avail = 1'b1;
          state_d             = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        cmd_o.div_sel_avail = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.load_avail = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
          case (kind_q)
            EK_FLUSH_BIN, EK_MARKER: begin
              cmd_o.emit_done   = 1'b1;
              cmd_o.emit_marker = (kind_q == EK_MARKER);
              cmd_o.restart     = 1'b1;
              bin_open_d        = 1'b0;
              past_end_d        = 1'b0;
            end
            EK_JUMP_OK: begin
              cmd_o.advance = 1'b1;
            end
            EK_JUMP_END: begin
              cmd_o.clear_peak = 1'b1;
              bin_open_d       = 1'b0;
              past_end_d       = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/interval_peak_rebinner_unit.sv
// interval_peak_rebinner_unit: top level of the peak-hold rebinner.
// Depends on ipr_pkg, ipr_in_if, ipr_out_if, ipr_regs, ipr_ctrl and ipr_dp.
//
// Takes scored intervals sorted by start and folds them into fixed-width,
// non-overlapping bins starting at range_start; each closed bin reports the
// largest-magnitude score and its tag plus a count of empty bins behind it,
// and a flush closes the run. Items are handled one at a time: an interval
// that is ignored or lands in the open bin passes through decode and
// classify only, and one that arrives after the run went past range_end
// only through decode. One that jumps past the open bin runs the serial
// divider once, and twice when the jump crosses range_end while the open
// bin still lies below it. A flush with a bin open also runs the divider
// once; a flush with no bin open does not run it. The divider works one
// quotient bit per cycle.
// A result waits in the output register while the next item is taken; the
// block stalls only when it must load a new result into a still-full output
// register.
module interval_peak_rebinner_unit #(
  parameter int unsigned COORD_BITS = ipr_pkg::COORD_BITS_DEF,
  parameter int unsigned SCORE_BITS = ipr_pkg::SCORE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ipr_in_if.sink                             seg_i,
  ipr_out_if.source                          bin_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ipr_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ipr_pkg::APB_DW-1:0]         pwdata,
  output logic [ipr_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import ipr_pkg::*;

  logic [COORD_BITS-1:0] range_start, range_end, bin_width;
  ipr_cmd_t              cmd;
  ipr_sts_t              sts;
  logic                  in_ready;

  // configuration registers
  ipr_regs #(.COORD_BITS(COORD_BITS)) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .range_start_o (range_start),
    .range_end_o   (range_end),
    .bin_width_o   (bin_width)
  );

  // sequencer
  ipr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign seg_i.ready = in_ready;

  // datapath
  ipr_dp #(.COORD_BITS(COORD_BITS), .SCORE_BITS(SCORE_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .range_start_i (range_start),
    .range_end_i   (range_end),
    .bin_width_i   (bin_width),
    .action_i      (seg_i.action),
    .seg_start_i   (seg_i.seg_start),
    .seg_end_i     (seg_i.seg_end),
    .seg_score_i   (seg_i.seg_score),
    .seg_tag_i     (seg_i.seg_tag),
    .out_ready_i   (bin_o.ready),
    .out_valid_o   (bin_o.valid),
    .bin_first_o   (bin_o.bin_first),
    .bin_last_o    (bin_o.bin_last),
    .peak_score_o  (bin_o.peak_score),
    .peak_tag_o    (bin_o.peak_tag),
    .tag_valid_o   (bin_o.tag_valid),
    .empty_after_o (bin_o.empty_after),
    .run_done_o    (bin_o.run_done)
  );

`ifndef SYNTH
  // no new item while the divider works
  a_ready_vs_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> !in_ready)
    else $error("input ready while divider busy");

  // divider never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending transfer");

  // a touched bin never ends before it starts
  a_bin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_o.valid && bin_o.tag_valid) |-> (bin_o.bin_last >= bin_o.bin_first))
    else $error("bin end below bin start");
`endif

endmodule
